// ===== rtl/core/nfba_pkg.sv =====
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared types and codes for the next-fit block allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

  localparam int OFF_W  = 10;
  localparam int SIZE_W = 11;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_PROBE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_BADSIZE  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTBLOCK = 3'd4;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_PROBE,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] req;
    logic [OFF_W-1:0]  off;
  } cmd_t;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic              used;
  } entry_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_U_RD,
    S_U_WR,
    S_A_WR,
    S_A_WR2,
    S_F_RD,
    S_F_CHK,
    S_P_RD,
    S_P_CHK,
    S_N_RD,
    S_N_CHK,
    S_FIN,
    S_D_RD,
    S_D_WR,
    S_D_END
  } state_t;

endpackage

// ===== rtl/core/nfba_front.sv =====
// ----------------------------------------------------------------------------
// nfba_front
// Takes commands, screens bad sizes and codes, and queues them (two deep).
// ----------------------------------------------------------------------------
module nfba_front
  import nfba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] arena,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [OFF_W-1:0]  in_block_start,
  output logic              q_valid,
  output cmd_t              q_cmd,
  input  logic              q_ready
);

  cmd_t       buf_r [2];
  logic [1:0] cnt_r;
  logic       wp_r;
  logic       rp_r;
  cmd_t       cls;
  logic       push;
  logic       pop;

  always_comb begin
    cls.req = in_request_size;
    cls.off = in_block_start;
    case (in_command)
      CMD_ALLOC: begin
        cls.op = (in_request_size == '0 || in_request_size > arena) ? OP_BAD : OP_ALLOC;
      end
      CMD_FREE:  cls.op = OP_FREE;
      CMD_PROBE: cls.op = OP_PROBE;
      default:   cls.op = OP_BAD;
    endcase
  end

  assign busy    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = buf_r[rp_r];
  assign push    = start && !busy;
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/nfba_back.sv =====
// ----------------------------------------------------------------------------
// nfba_back
// Block table, rover and the sequencer that searches, splits and merges.
// ----------------------------------------------------------------------------
module nfba_back
  import nfba_pkg::*;
#(
  parameter int MEM_UNITS  = 1024,
  parameter int MAX_BLOCKS = 64
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_arena_size,
  output logic [SIZE_W-1:0] arena,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_ready,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [OFF_W-1:0]  out_result_offset,
  output logic [SIZE_W-1:0] out_result_size
);

  localparam int IW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int ARENA_MAX = (MEM_UNITS > 2047) ? 2047 : MEM_UNITS;
  localparam logic [SIZE_W-1:0] ARENA_RST = SIZE_W'(ARENA_MAX);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

  entry_t mem [MAX_BLOCKS];
  entry_t rd_r;

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] arena_r;
  logic [CW-1:0]     count_r;
  logic [IW-1:0]     rover_r;
  cmd_t              cmd_r;
  logic [IW-1:0]     ptr_r;
  logic [CW-1:0]     scan_r;
  logic [CW-1:0]     mm_r;
  logic [IW-1:0]     idx_r;
  logic [IW-1:0]     lidx_r;
  entry_t            cur_r, prv_r, nx_r;
  logic              prv_free_r, nxt_free_r;
  logic [1:0]        rem_r;

  logic              mem_we;
  logic [IW-1:0]     mem_wa, mem_ra;
  entry_t            mem_wd;
  logic              emit;
  logic [2:0]        emit_st;
  logic [OFF_W-1:0]  emit_off;
  logic [SIZE_W-1:0] emit_size;

  logic              cfg_fire, fit, exact, ptr_last, match;
  logic [IW-1:0]     ptr_inc, lidx_c;
  logic [OFF_W-1:0]  left_off;
  logic [SIZE_W-1:0] total;
  logic [SIZE_W-1:0] cfg_clamp;
  logic [CW-1:0]     cnt_dec;
  logic [CW-1:0]     j_rm;

  assign arena     = arena_r;
  assign cfg_ready = (state_r == S_IDLE) && !q_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign fit      = !rd_r.used && (rd_r.size >= cmd_r.req);
  assign exact    = (rd_r.size == cmd_r.req);
  assign ptr_last = (CW'(ptr_r) + CW'(1) == count_r);
  assign ptr_inc  = ptr_last ? '0 : ptr_r + IW'(1);
  assign match    = (rd_r.off == cmd_r.off);
  assign left_off = prv_free_r ? prv_r.off : cur_r.off;
  assign total    = cur_r.size + (prv_free_r ? prv_r.size : '0)
                               + (nxt_free_r ? nx_r.size : '0);
  assign lidx_c   = prv_free_r ? idx_r - IW'(1) : idx_r;
  assign cnt_dec  = count_r - CW'(1);
  assign j_rm     = CW'(lidx_r) + CW'(1);

  always_comb begin
    cfg_clamp = cfg_arena_size;
    if (cfg_arena_size == '0) cfg_clamp = SIZE_W'(1);
    if (cfg_arena_size > ARENA_RST) cfg_clamp = ARENA_RST;
  end

  // Table memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (cfg_fire) begin
          state_nxt = S_INIT;
        end else if (q_valid) begin
          case (q_cmd.op)
            OP_BAD:   state_nxt = S_IDLE;
            OP_ALLOC: state_nxt = S_A_RD;
            default:  state_nxt = S_F_RD;
          endcase
        end
      end
      S_A_RD: state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (fit) begin
          if (exact || count_r >= CNT_MAX) state_nxt = S_IDLE;
          else if (count_r > CW'(ptr_r) + CW'(1)) state_nxt = S_U_RD;
          else state_nxt = S_A_WR;
        end else if (scan_r + CW'(1) == count_r) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_U_RD: state_nxt = S_U_WR;
      S_U_WR: begin
        state_nxt = (mm_r - CW'(1) > CW'(idx_r) + CW'(1)) ? S_U_RD : S_A_WR;
      end
      S_A_WR:  state_nxt = S_A_WR2;
      S_A_WR2: state_nxt = S_IDLE;
      S_F_RD:  state_nxt = S_F_CHK;
      S_F_CHK: begin
        if (match) begin
          state_nxt = (cmd_r.op == OP_FREE && !rd_r.used) ? S_IDLE : S_P_RD;
        end else if (ptr_last) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_P_RD:  state_nxt = S_P_CHK;
      S_P_CHK: state_nxt = S_N_RD;
      S_N_RD:  state_nxt = S_N_CHK;
      S_N_CHK: state_nxt = S_FIN;
      S_FIN: begin
        if (cmd_r.op == OP_PROBE || !(prv_free_r || nxt_free_r)) state_nxt = S_IDLE;
        else if (CW'(lidx_c) + CW'(2) < count_r) state_nxt = S_D_RD;
        else state_nxt = S_D_END;
      end
      S_D_RD: state_nxt = S_D_WR;
      S_D_WR: state_nxt = (CW'(ptr_r) + CW'(2) < count_r) ? S_D_RD : S_D_END;
      S_D_END: begin
        if (rem_r == 2'd1) state_nxt = S_IDLE;
        else if (CW'(lidx_r) + CW'(2) < cnt_dec) state_nxt = S_D_RD;
        else state_nxt = S_D_END;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: memory control, queue pop and result
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = ptr_r;
    mem_wd    = rd_r;
    mem_ra    = ptr_r;
    q_ready   = 1'b0;
    emit      = 1'b0;
    emit_st   = ST_OK;
    emit_off  = '0;
    emit_size = '0;
    case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = '{off: '0, size: arena_r, used: 1'b0};
      end
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && q_cmd.op == OP_BAD) begin
          emit    = 1'b1;
          emit_st = ST_BADSIZE;
        end
      end
      S_A_CHK: begin
        if (fit && exact) begin
          mem_we    = 1'b1;
          mem_wd    = '{off: rd_r.off, size: rd_r.size, used: 1'b1};
          emit      = 1'b1;
          emit_off  = rd_r.off;
          emit_size = cmd_r.req;
        end else if (fit && count_r >= CNT_MAX) begin
          emit    = 1'b1;
          emit_st = ST_FULL;
        end else if (!fit && scan_r + CW'(1) == count_r) begin
          emit    = 1'b1;
          emit_st = ST_NOFIT;
        end
      end
      S_U_RD: mem_ra = IW'(mm_r - CW'(1));
      S_U_WR: begin
        mem_we = 1'b1;
        mem_wa = IW'(mm_r);
      end
      S_A_WR: begin
        mem_we = 1'b1;
        mem_wa = idx_r + IW'(1);
        mem_wd = '{off:  OFF_W'({1'b0, cur_r.off} + cmd_r.req),
                   size: cur_r.size - cmd_r.req, used: 1'b0};
      end
      S_A_WR2: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r;
        mem_wd    = '{off: cur_r.off, size: cmd_r.req, used: 1'b1};
        emit      = 1'b1;
        emit_off  = cur_r.off;
        emit_size = cmd_r.req;
      end
      S_F_CHK: begin
        if ((match && cmd_r.op == OP_FREE && !rd_r.used) || (!match && ptr_last)) begin
          emit    = 1'b1;
          emit_st = ST_NOTBLOCK;
        end
      end
      S_P_RD: mem_ra = idx_r - IW'(1);
      S_N_RD: mem_ra = idx_r + IW'(1);
      S_FIN: begin
        if (cmd_r.op == OP_PROBE) begin
          emit      = 1'b1;
          emit_off  = left_off;
          emit_size = total;
        end else begin
          mem_we = 1'b1;
          mem_wa = lidx_c;
          mem_wd = '{off: left_off, size: total, used: 1'b0};
          if (!(prv_free_r || nxt_free_r)) begin
            emit      = 1'b1;
            emit_off  = left_off;
            emit_size = total;
          end
        end
      end
      S_D_RD: mem_ra = ptr_r + IW'(1);
      S_D_WR: mem_we = 1'b1;
      S_D_END: begin
        if (rem_r == 2'd1) begin
          emit      = 1'b1;
          emit_off  = cur_r.off;
          emit_size = cur_r.size;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      arena_r   <= ARENA_RST;
      count_r   <= CW'(1);
      rover_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= emit;
      case (state_r)
        S_INIT: begin
          count_r <= CW'(1);
          rover_r <= '0;
        end
        S_IDLE: if (cfg_fire) arena_r <= cfg_clamp;
        S_A_CHK: if (fit && exact) rover_r <= ptr_inc;
        S_A_WR2: begin
          count_r <= count_r + CW'(1);
          rover_r <= idx_r + IW'(1);
        end
        S_D_END: begin
          count_r <= cnt_dec;
          if (CW'(rover_r) == j_rm) begin
            if (CW'(rover_r) >= cnt_dec) rover_r <= '0;
          end else if (CW'(rover_r) > j_rm) begin
            rover_r <= rover_r - IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_status        <= emit_st;
    out_result_offset <= emit_off;
    out_result_size   <= emit_size;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cmd_r  <= q_cmd;
          ptr_r  <= (q_cmd.op == OP_ALLOC) ? rover_r : '0;
          scan_r <= '0;
        end
      end
      S_A_CHK: begin
        if (fit) begin
          idx_r <= ptr_r;
          cur_r <= rd_r;
          mm_r  <= count_r;
        end else begin
          ptr_r  <= ptr_inc;
          scan_r <= scan_r + CW'(1);
        end
      end
      S_U_WR: mm_r <= mm_r - CW'(1);
      S_F_CHK: begin
        if (match) begin
          idx_r <= ptr_r;
          cur_r <= rd_r;
        end else begin
          ptr_r <= ptr_r + IW'(1);
        end
      end
      S_P_CHK: begin
        prv_r      <= rd_r;
        prv_free_r <= (idx_r != '0) && !rd_r.used;
      end
      S_N_CHK: begin
        nx_r       <= rd_r;
        nxt_free_r <= (CW'(idx_r) + CW'(1) < count_r) && !rd_r.used;
      end
      S_FIN: begin
        rem_r      <= {1'b0, prv_free_r} + {1'b0, nxt_free_r};
        lidx_r     <= lidx_c;
        ptr_r      <= lidx_c + IW'(1);
        cur_r.off  <= left_off;
        cur_r.size <= total;
      end
      S_D_WR: ptr_r <= ptr_r + IW'(1);
      S_D_END: begin
        rem_r <= rem_r - 2'd1;
        ptr_r <= lidx_r + IW'(1);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/next_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// next_fit_block_allocator
// Next-fit allocator over an address-ordered block table, with split on
// allocate and coalescing of free neighbours on free.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       start / busy              in_command, in_request_size,
//                                     in_block_start
//  out      out_valid (1-cycle)       out_status, out_result_offset,
//                                     out_result_size
//  cfg      cfg_valid / cfg_ready     cfg_arena_size
//
//  Steps: a bad command is answered from idle as it leaves the queue.
//  Allocate reads and checks table entries from the rover on, then for a
//  split moves later entries up and writes the two halves; free/probe scan
//  from entry zero to find the offset, read both neighbours and, for free,
//  write the merged entry, then per merge move later entries down.
//  The table memory's one read and one write a cycle bound these steps.
//  Reset (and every arena_size write) rebuilds entry zero in the init state.
//  The front queue holds two transactions; busy rises only when it is full.
//  Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module next_fit_block_allocator
  import nfba_pkg::*;
#(
  parameter int MEM_UNITS  = 1024,
  parameter int MAX_BLOCKS = 64
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [OFF_W-1:0]  in_block_start,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [OFF_W-1:0]  out_result_offset,
  output logic [SIZE_W-1:0] out_result_size,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_arena_size
);

  logic              q_valid;
  logic              q_ready;
  cmd_t              q_cmd;
  logic [SIZE_W-1:0] arena;

  // Front: screens commands and queues them
  nfba_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .arena           (arena),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_request_size (in_request_size),
    .in_block_start  (in_block_start),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_ready         (q_ready)
  );

  // Back: table owner and sequencer
  nfba_back #(
    .MEM_UNITS  (MEM_UNITS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_arena_size    (cfg_arena_size),
    .arena             (arena),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_ready           (q_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_result_offset (out_result_offset),
    .out_result_size   (out_result_size)
  );

endmodule
